FILE: rtl/core/fvss_pkg.sv
// shared constants and types for the four-voice square synthesiser
package fvss_pkg;

    // default geometry
    localparam int VOICE_COUNT_DEF = 4;
    localparam int PHASE_BITS_DEF  = 24;

    // voices that own configuration registers
    localparam int REG_VOICES = 4;

    // register field widths
    localparam int STEP_W   = 24;
    localparam int LEVEL_W  = 31;
    localparam int AMP_LSB  = 16;
    localparam int AMP_W    = 15;
    localparam int SMOOTH_W = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = LEVEL_W;

    // register index map
    localparam int REG_STEP_BASE  = 0;
    localparam int REG_LEVEL_BASE = 4;

    // datapath widths
    localparam int FILTER_W = 17;
    localparam int SAMPLE_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // mixer constants: clamp to +-1.0 in q1.15, scale by 2^15 - 1
    localparam int MIX_LIMIT   = 32768;
    localparam int SCALE_SHIFT = 15;

    // per-voice control from the sequencing logic
    typedef struct packed {
        logic advance;
        logic clear;
    } voice_ctrl_t;

endpackage

FILE: rtl/core/four_voice_square_synth_top.sv
// top level of the four-voice square-wave synthesiser
//
// usage:
//   s_tvalid/s_tready/s_tdata carry tick requests; one transaction with tick set asks
//   for one audio sample, a transaction with tick clear is taken and dropped
//   m_tvalid/m_tready/m_tdata carry the signed 16-bit mixed samples, one per tick
//   cfg_we/cfg_index/cfg_data write the step and level registers; writes are taken
//   in the cycle they are presented; the user must write only while no sample is in
//   flight, and the block itself does not enforce this
// order: a taken tick passes the input register, the voice stage and the output
//   register before m_tvalid rises
// throughput: one tick per cycle while the output is not stalled; the per-voice
//   multiply and filter update are combinational, all voices in parallel in the voice stage
// reset: step, level, phase, filter and valid registers clear, so the output is silent
// stall: each stage holds its item while the stage after it is full; a stalled
//   output register does not stop the input while earlier stages still have room
module four_voice_square_synth_top #(
    parameter int VOICE_COUNT = fvss_pkg::VOICE_COUNT_DEF,
    parameter int PHASE_BITS  = fvss_pkg::PHASE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fvss_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] tick, [7:1] zero
    // sample stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fvss_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [15:0] sample
    // configuration write port
    input  logic                                cfg_we,
    input  logic [fvss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fvss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // input register: holds one pending tick
    logic in_valid_reg;
    logic in_valid_next;
    logic in_ready;

    // voice stage occupancy
    logic voice_valid_reg;
    logic voice_valid_next;
    logic voice_ready;
    logic advance;

    logic mix_ready;
    logic signed [fvss_pkg::SAMPLE_W-1:0] sample;

    logic [VOICE_COUNT-1:0][fvss_pkg::FILTER_W-1:0] contrib;

    // a tick moves into the voice stage when that stage is free or drains this cycle
    assign voice_ready = !voice_valid_reg || mix_ready;
    assign advance     = in_valid_reg && voice_ready;
    assign in_ready    = !in_valid_reg || voice_ready;
    assign s_tready    = in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = s_tvalid && s_tdata[0];   // tick clear makes no sample
    end

    always_comb
    begin
        voice_valid_next = voice_valid_reg;
        if (voice_ready)
            voice_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            voice_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            voice_valid_reg <= voice_valid_next;
        end
    end

    // per-voice registers and datapath; voices beyond the register map stay silent
    for (genvar v = 0; v < VOICE_COUNT; v++)
    begin : g_voice
        logic [fvss_pkg::STEP_W-1:0]  step;
        logic [fvss_pkg::LEVEL_W-1:0] level;
        fvss_pkg::voice_ctrl_t        ctrl;

        if (v < fvss_pkg::REG_VOICES)
        begin : g_regs
            localparam logic [fvss_pkg::CFG_INDEX_W-1:0] STEP_IDX =
                fvss_pkg::CFG_INDEX_W'(fvss_pkg::REG_STEP_BASE + v);
            localparam logic [fvss_pkg::CFG_INDEX_W-1:0] LEVEL_IDX =
                fvss_pkg::CFG_INDEX_W'(fvss_pkg::REG_LEVEL_BASE + v);

            logic [fvss_pkg::STEP_W-1:0]  step_reg;
            logic [fvss_pkg::STEP_W-1:0]  step_next;
            logic [fvss_pkg::LEVEL_W-1:0] level_reg;
            logic [fvss_pkg::LEVEL_W-1:0] level_next;
            logic                         level_wr;

            assign level_wr = cfg_we && (cfg_index == LEVEL_IDX);

            always_comb
            begin
                step_next  = step_reg;
                level_next = level_reg;
                if (cfg_we && (cfg_index == STEP_IDX))
                    step_next = cfg_data[fvss_pkg::STEP_W-1:0];
                if (level_wr)
                    level_next = cfg_data;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg  <= '0;
                    level_reg <= '0;
                end
                else
                begin
                    step_reg  <= step_next;
                    level_reg <= level_next;
                end
            end

            assign step       = step_reg;
            assign level      = level_reg;
            // muting a voice also empties its filter
            assign ctrl.clear = level_wr &&
                (cfg_data[fvss_pkg::AMP_LSB +: fvss_pkg::AMP_W] == '0);
        end
        else
        begin : g_noregs
            assign step       = '0;
            assign level      = '0;
            assign ctrl.clear = 1'b0;
        end

        assign ctrl.advance = advance;

        fvss_voice #(
            .PHASE_BITS (PHASE_BITS)
        ) u_voice (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .step    (step),
            .level   (level),
            .contrib (contrib[v])
        );
    end

    fvss_mixer #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_valid (voice_valid_reg),
        .mix_ready (mix_ready),
        .contrib   (contrib),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sample    (sample)
    );

    assign m_tdata = fvss_pkg::OUT_TDATA_W'(sample);

    // a voice-stage item only ever comes from a pending tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(voice_valid_reg) |-> $past(in_valid_reg))
    else $error("voice stage filled without a pending tick");

    // a transaction with tick clear never produces work
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tdata[0]) |=> !in_valid_reg)
    else $error("tick-clear transaction entered the pipeline");

    // the scaled mix never reaches the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata != 16'h8000))
    else $error("sample outside the clamped range");

    // input is only refused while a tick is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
    else $error("input stalled with an empty input register");

endmodule

FILE: rtl/core/fvss_voice.sv
// one square-wave voice: phase accumulator, one-pole lowpass and contribution register
module fvss_voice #(
    parameter int PHASE_BITS = fvss_pkg::PHASE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fvss_pkg::voice_ctrl_t                ctrl,
    input  logic [fvss_pkg::STEP_W-1:0]          step,
    input  logic [fvss_pkg::LEVEL_W-1:0]         level,
    output logic signed [fvss_pkg::FILTER_W-1:0] contrib
);

    logic [fvss_pkg::AMP_W-1:0]           amp;
    logic [fvss_pkg::SMOOTH_W-1:0]        smooth;
    logic                                 active;
    logic [PHASE_BITS-1:0]                phase_reg;
    logic [PHASE_BITS-1:0]                phase_next;
    logic signed [fvss_pkg::FILTER_W-1:0] filter_reg;
    logic signed [fvss_pkg::FILTER_W-1:0] filter_next;
    logic signed [fvss_pkg::FILTER_W-1:0] contrib_reg;
    logic signed [fvss_pkg::FILTER_W-1:0] contrib_next;
    logic signed [15:0]                   x;
    logic signed [17:0]                   diff;
    logic signed [34:0]                   prod;
    logic signed [18:0]                   quot;
    logic signed [18:0]                   filt_sum;
    logic signed [fvss_pkg::FILTER_W-1:0] filt_new;

    assign amp    = level[fvss_pkg::AMP_LSB +: fvss_pkg::AMP_W];
    assign smooth = level[fvss_pkg::SMOOTH_W-1:0];
    assign active = (step != '0) && (amp != '0);

    // phase wraps modulo 2^PHASE_BITS
    assign phase_next = phase_reg + PHASE_BITS'(step);

    // square: +amp in the first half of the cycle, -amp in the second
    always_comb
    begin
        if (phase_next[PHASE_BITS-1])
            x = -$signed({1'b0, amp});
        else
            x = $signed({1'b0, amp});
    end

    // filt = x + s*(filt - x), product shifted down with truncation towards zero
    assign diff = {filter_reg[fvss_pkg::FILTER_W-1], filter_reg} - {{2{x[15]}}, x};
    assign prod = $signed({1'b0, smooth}) * diff;
    assign quot = prod[34:16] + {18'd0, (prod[34] && (prod[15:0] != '0))};
    assign filt_sum = {{3{x[15]}}, x} + quot;
    assign filt_new = filt_sum[fvss_pkg::FILTER_W-1:0];

    always_comb
    begin
        filter_next  = filter_reg;
        contrib_next = contrib_reg;
        if (ctrl.clear)
            filter_next = '0;
        else if (ctrl.advance && active)
            filter_next = filt_new;
        if (ctrl.advance)
            contrib_next = active ? filt_new : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            filter_reg <= '0;
        end
        else
        begin
            if (ctrl.advance && active)
                phase_reg <= phase_next;
            filter_reg <= filter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        contrib_reg <= contrib_next;
    end

    assign contrib = contrib_reg;

endmodule

FILE: rtl/core/fvss_mixer.sv
// voice summation, clamp to full scale, scaling and the output register
module fvss_mixer #(
    parameter int VOICE_COUNT = fvss_pkg::VOICE_COUNT_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            mix_valid,
    output logic                                            mix_ready,
    input  logic [VOICE_COUNT-1:0][fvss_pkg::FILTER_W-1:0]  contrib,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic signed [fvss_pkg::SAMPLE_W-1:0]            sample
);

    localparam int SUM_W = fvss_pkg::FILTER_W + $clog2(VOICE_COUNT);
    localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(fvss_pkg::MIX_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_LO = -SUM_W'(fvss_pkg::MIX_LIMIT);

    logic signed [SUM_W-1:0]                 total;
    logic signed [SUM_W-1:0]                 clamped;
    logic signed [fvss_pkg::FILTER_W-1:0]    t;
    logic signed [31:0]                      prod;
    logic signed [16:0]                      quot;
    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    logic signed [fvss_pkg::SAMPLE_W-1:0]    sample_reg;

    always_comb
    begin
        total = '0;
        for (int v = 0; v < VOICE_COUNT; v++)
            total = total + SUM_W'($signed(contrib[v]));
    end

    always_comb
    begin
        if (total > LIM_HI)
            clamped = LIM_HI;
        else if (total < LIM_LO)
            clamped = LIM_LO;
        else
            clamped = total;
    end

    assign t = clamped[fvss_pkg::FILTER_W-1:0];

    // t * (2^15 - 1) as shift and subtract, then truncate towards zero
    assign prod = {t, {fvss_pkg::SCALE_SHIFT{1'b0}}} - {{15{t[fvss_pkg::FILTER_W-1]}}, t};
    assign quot = prod[31:fvss_pkg::SCALE_SHIFT]
                + {16'd0, (prod[31] && (prod[fvss_pkg::SCALE_SHIFT-1:0] != '0))};

    assign mix_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mix_ready)
            out_valid_next = mix_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (mix_ready && mix_valid)
            sample_reg <= quot[fvss_pkg::SAMPLE_W-1:0];
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

FILE: bench/four_voice_square_synth_top_tb.sv
// self-checking bench for the four-voice square synthesiser: ticks in, mixed samples out
`timescale 1ns / 1ps

module four_voice_square_synth_top_tb;

    // stop point for the stimulus (accepted tick transactions) and the cycle guard
    localparam int TICK_TARGET = 1650;
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last sample; the pipeline is three stages deep
    localparam int DRAIN_CYCLES = 8;

    // expected-sample store with its own copy of the voice state and registers
    class mix_scoreboard;
        logic [fvss_pkg::STEP_W-1:0]          step_reg   [fvss_pkg::REG_VOICES];
        logic [fvss_pkg::LEVEL_W-1:0]         level_reg  [fvss_pkg::REG_VOICES];
        logic [fvss_pkg::PHASE_BITS_DEF-1:0]  phase_acc  [fvss_pkg::REG_VOICES];
        logic signed [fvss_pkg::FILTER_W-1:0] filter_out [fvss_pkg::REG_VOICES];
        logic signed [fvss_pkg::SAMPLE_W-1:0] expected_samples [$];
        int                                   mismatch_count;

        function new();
            for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
            begin
                step_reg[v]   = '0;
                level_reg[v]  = '0;
                phase_acc[v]  = '0;
                filter_out[v] = '0;
            end
            mismatch_count = 0;
        endfunction

        // register write; a zero amplitude empties the voice's filter
        function void write_reg(int index, logic [fvss_pkg::CFG_DATA_W-1:0] data);
            int v;
            if (index < fvss_pkg::REG_LEVEL_BASE)
            begin
                v = index - fvss_pkg::REG_STEP_BASE;
                step_reg[v] = data[fvss_pkg::STEP_W-1:0];
            end
            else
            begin
                v = index - fvss_pkg::REG_LEVEL_BASE;
                level_reg[v] = data[fvss_pkg::LEVEL_W-1:0];
                if (data[fvss_pkg::AMP_LSB +: fvss_pkg::AMP_W] == '0)
                    filter_out[v] = '0;
            end
        endfunction

        // advance every active voice by one tick and mix
        function logic signed [fvss_pkg::SAMPLE_W-1:0] predict_mix();
            int     total;
            int     amp;
            int     square;
            int     smooth;
            longint prod;
            longint scaled;
            total = 0;
            for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
            begin
                amp = level_reg[v][fvss_pkg::AMP_LSB +: fvss_pkg::AMP_W];
                if (step_reg[v] == '0 || amp == 0)
                    continue;
                phase_acc[v] = phase_acc[v] + step_reg[v];
                square = phase_acc[v][fvss_pkg::PHASE_BITS_DEF-1] ? -amp : amp;
                smooth = level_reg[v][fvss_pkg::SMOOTH_W-1:0];
                prod = longint'(smooth) * longint'(int'(filter_out[v]) - square);
                // signed division truncates toward zero
                filter_out[v] = square + int'(prod / longint'(65536));
                total += int'(filter_out[v]);
            end
            if (total > fvss_pkg::MIX_LIMIT)
                total = fvss_pkg::MIX_LIMIT;
            if (total < -fvss_pkg::MIX_LIMIT)
                total = -fvss_pkg::MIX_LIMIT;
            scaled = (longint'(total) * ((1 << fvss_pkg::SCALE_SHIFT) - 1))
                   / (longint'(1) << fvss_pkg::SCALE_SHIFT);
            return scaled[fvss_pkg::SAMPLE_W-1:0];
        endfunction

        function void note_tick(logic tick);
            if (tick)
                expected_samples.push_back(predict_mix());
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_sample(logic [fvss_pkg::OUT_TDATA_W-1:0] data);
            logic signed [fvss_pkg::SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample %0d with no tick pending",
                                          $signed(data[fvss_pkg::SAMPLE_W-1:0])));
                return;
            end
            want = expected_samples.pop_front();
            if (data[fvss_pkg::SAMPLE_W-1:0] !== want)
                report_mismatch($sformatf("sample %0d, expected %0d",
                                          $signed(data[fvss_pkg::SAMPLE_W-1:0]), want));
        endtask
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [fvss_pkg::IN_TDATA_W-1:0]      s_tdata;     // [0] tick, [7:1] zero
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [fvss_pkg::OUT_TDATA_W-1:0]     m_tdata;     // [15:0] sample
    logic                                 cfg_we;
    logic [fvss_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [fvss_pkg::CFG_DATA_W-1:0]      cfg_data;

    mix_scoreboard sb;
    int            ticks_sent = 0;
    int            cycle_count;

    four_voice_square_synth_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // transaction monitor: both handshakes are sampled at the edge itself
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready)
                sb.check_sample(m_tdata);
        end
    end

    // one register write per cycle; the caller lowers cfg_we after the last one
    task set_reg(int index, logic [fvss_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index[fvss_pkg::CFG_INDEX_W-1:0];
        cfg_data  <= data;
        sb.write_reg(index, data);
        @(posedge clk);
    endtask

    // offer a run of tick transactions in bursts; zero_pct of them carry tick clear
    task play_ticks(int count, int zero_pct, bit gapless);
        int burst_left;
        int gap;
        bit tick;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < count; i++)
        begin
            tick = ($urandom_range(0, 99) >= zero_pct);
            s_tvalid <= 1'b1;
            s_tdata  <= {{(fvss_pkg::IN_TDATA_W-1){1'b0}}, tick};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            ticks_sent++;
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = gapless ? 0 : $urandom_range(1, 8);
                // no gap after the last item, so valid is lowered only once
                if (gap > 0 && i != count - 1)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        // lower valid and let an idle edge pass so the monitor has noted the last transaction
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // let every expected sample arrive, then stay idle so that any stray sample is caught
    task settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sample side: stall pattern of its own, with an occasional long hold-off
    initial
    begin
        int seg;
        int len;
        int stall_pct;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        seg = 0;
        forever
        begin
            if (seg == 8 || $urandom_range(0, 11) == 0)
            begin
                // long hold-off: the pipeline fills and the tick side stalls
                m_tready <= 1'b0;
                repeat ($urandom_range(60, 150)) @(posedge clk);
            end
            else
            begin
                len = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 70;
                endcase
                repeat (len)
                begin
                    m_tready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    // cycle guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("four_voice_square_synth_top regression: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        int                              phase_no;
        logic [fvss_pkg::CFG_DATA_W-1:0] word;
        logic [fvss_pkg::AMP_W-1:0]      amp;
        logic [fvss_pkg::SMOOTH_W-1:0]   smooth;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset every voice is silent; a tick-clear transaction gives nothing
        play_ticks(2, 0, 1'b1);
        play_ticks(1, 100, 1'b1);
        settle();

        // half-cycle step: voice 0 flips sign on every tick at full scale
        set_reg(fvss_pkg::REG_STEP_BASE + 0, 31'h0080_0000);
        set_reg(fvss_pkg::REG_LEVEL_BASE + 0, {15'h7FFF, 16'h0000});
        cfg_we <= 1'b0;
        play_ticks(3, 0, 1'b1);
        settle();

        // voices 1 to 3 high, voice 0 low, all unsmoothed: the mix saturates positive
        for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
        begin
            set_reg(fvss_pkg::REG_STEP_BASE + v, 31'h0000_0001);
            set_reg(fvss_pkg::REG_LEVEL_BASE + v, {15'h7FFF, 16'h0000});
        end
        cfg_we <= 1'b0;
        play_ticks(2, 0, 1'b1);
        settle();

        // step past half a cycle, junk above the step field: saturates negative
        for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
            set_reg(fvss_pkg::REG_STEP_BASE + v, {7'h7F, 24'hC0_0000});
        cfg_we <= 1'b0;
        play_ticks(2, 0, 1'b0);
        settle();

        // heaviest smoothing, filters creep towards the square level
        for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
        begin
            set_reg(fvss_pkg::REG_STEP_BASE + v, 31'h0040_0000);
            set_reg(fvss_pkg::REG_LEVEL_BASE + v, {15'h7FFF, 16'hFFFF});
        end
        cfg_we <= 1'b0;
        play_ticks(4, 0, 1'b0);
        settle();

        // zero amplitude clears voice 1's filter; zero step parks voice 2
        set_reg(fvss_pkg::REG_LEVEL_BASE + 1, {15'h0000, 16'h1234});
        set_reg(fvss_pkg::REG_STEP_BASE + 2, 31'h0000_0000);
        cfg_we <= 1'b0;
        play_ticks(3, 0, 1'b0);
        play_ticks(1, 100, 1'b1);

        // random phases: new voice settings while idle, then a run of ticks
        phase_no = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            settle();
            for (int v = 0; v < fvss_pkg::REG_VOICES; v++)
            begin
                if (phase_no == 0 || $urandom_range(0, 9) < 7)
                begin
                    // upper bits are random; only the low 24 are the step
                    word = fvss_pkg::CFG_DATA_W'($urandom);
                    case ($urandom_range(0, 5))
                        0:       word[fvss_pkg::STEP_W-1:0] = '0;
                        1:       word[fvss_pkg::STEP_W-1:0] =
                                     fvss_pkg::STEP_W'($urandom_range(1, 255));
                        2:       word[fvss_pkg::STEP_W-1:0] =
                                     fvss_pkg::STEP_W'($urandom_range(1 << 18, 1 << 22));
                        3:       word[fvss_pkg::STEP_W-1:0] =
                                     fvss_pkg::STEP_W'($urandom_range(1 << 23,
                                                                      (1 << 24) - 1));
                        4:       word[fvss_pkg::STEP_W-1:0] = '1;
                        default: ;
                    endcase
                    set_reg(fvss_pkg::REG_STEP_BASE + v, word);
                end
                if (phase_no == 0 || $urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 9))
                        0:       amp = '0;
                        1, 2:    amp = '1;
                        default: amp = fvss_pkg::AMP_W'($urandom_range(1,
                                           (1 << fvss_pkg::AMP_W) - 1));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       smooth = '0;
                        1:       smooth = '1;
                        default: smooth = fvss_pkg::SMOOTH_W'($urandom);
                    endcase
                    set_reg(fvss_pkg::REG_LEVEL_BASE + v, {amp, smooth});
                end
            end
            cfg_we <= 1'b0;
            play_ticks($urandom_range(40, 120), $urandom_range(0, 20),
                       $urandom_range(0, 4) == 0);
            phase_no++;
        end

        // drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("four_voice_square_synth_top regression: pass");
        else
            $display("four_voice_square_synth_top regression: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fvss_pkg.sv
rtl/core/fvss_voice.sv
rtl/core/fvss_mixer.sv
rtl/core/four_voice_square_synth_top.sv
bench/four_voice_square_synth_top_tb.sv
